@@ hdl/chunk_reassembler_assert.svh @@
// Assertion macros shared by the chunk reassembler modules.
`ifndef CHUNK_REASSEMBLER_ASSERT_SVH
`define CHUNK_REASSEMBLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHRSM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chunk reassembler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHRSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chunk reassembler assertion failed");

`endif

@@ hdl/chrsm_pkg.sv @@
// Types and constants shared by the chunk reassembler modules.
package chrsm_pkg;

   localparam int BYTE_W       = 8;
   localparam int ADDR_W       = 10;
   localparam int LEN_W        = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int HEADER_BYTES = 3;
   localparam int CMP_W        = 18;

   // Positions of the header bytes within the frame buffer.
   localparam int HDR_TYPE_POS   = 0;
   localparam int HDR_LEN_LO_POS = 1;
   localparam int HDR_LEN_HI_POS = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_TAG = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_TAG  = 2'd1;

   localparam logic [BYTE_W-1:0] FIRST_TAG_RESET = 8'd1;
   localparam logic [BYTE_W-1:0] LAST_TAG_RESET  = 8'd3;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] chunk_byte;
      logic              chunk_start;
      logic              chunk_end;
      logic              first_tag;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/chrsm_front.sv @@
// Front part: takes input transfers and classifies tag bytes.
module chrsm_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [chrsm_pkg::BYTE_W-1:0]  req_chunk_byte,
   input  logic                          req_chunk_start,
   input  logic                          req_chunk_end,
   input  logic [chrsm_pkg::BYTE_W-1:0]  first_tag_code,
   input  chrsm_pkg::queue_status_type   q_status,
   output logic                          push,
   output chrsm_pkg::item_type           push_item
);
   import chrsm_pkg::*;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_item.chunk_byte  = req_chunk_byte;
      push_item.chunk_start = req_chunk_start;
      push_item.chunk_end   = req_chunk_end;
      push_item.first_tag   = req_chunk_start && (req_chunk_byte == first_tag_code);
   end

endmodule

@@ hdl/chrsm_queue.sv @@
// Short queue of classified items between the front and the back.
module chrsm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  chrsm_pkg::item_type         push_item,
   input  logic                        pop,
   output chrsm_pkg::item_type         pop_item,
   output chrsm_pkg::queue_status_type q_status
);
   import chrsm_pkg::*;
   `include "chunk_reassembler_assert.svh"

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CHRSM_ASSERT_NOW(a_count_range, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `CHRSM_ASSERT_NEXT(a_pop_drains, pop && !push, count_ff == $past(count_ff) - QCNT_W'(1))

endmodule

@@ hdl/chrsm_back.sv @@
// Back part: frame state update and the registered result stage.
module chrsm_back #(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [chrsm_pkg::BYTE_W-1:0]    first_tag_code,
   input  logic [chrsm_pkg::BYTE_W-1:0]    last_tag_code,
   input  chrsm_pkg::queue_status_type     q_status,
   input  chrsm_pkg::item_type             pop_item,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_write_valid,
   output logic [chrsm_pkg::ADDR_W-1:0]    rsp_write_addr,
   output logic [chrsm_pkg::BYTE_W-1:0]    rsp_write_data,
   output logic                            rsp_frame_done,
   output logic                            rsp_frame_ok,
   output logic [chrsm_pkg::BYTE_W-1:0]    rsp_message_type,
   output logic [chrsm_pkg::LEN_W-1:0]     rsp_payload_length
);
   import chrsm_pkg::*;
   `include "chunk_reassembler_assert.svh"

   localparam int CW = $clog2(BUFFER_BYTES + 1);

   logic              frame_open_ff, frame_open_in;
   logic              accepting_ff, accepting_in;
   logic [BYTE_W-1:0] chunk_tag_ff, chunk_tag_in;
   logic [CW-1:0]     byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] header_type_ff, header_type_in;
   logic [BYTE_W-1:0] length_low_ff, length_low_in;
   logic [BYTE_W-1:0] length_high_ff, length_high_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              write_valid_ff, write_valid_in;
   logic [ADDR_W-1:0] write_addr_ff, write_addr_in;
   logic [BYTE_W-1:0] write_data_ff, write_data_in;
   logic              frame_done_ff, frame_done_in;
   logic              frame_ok_ff, frame_ok_in;
   logic [BYTE_W-1:0] message_type_ff, message_type_in;
   logic [LEN_W-1:0]  payload_length_ff, payload_length_in;

   logic              have_header;
   logic              fits;
   logic [LEN_W-1:0]  plen;

   // The result stage is free, or its transfer completes this cycle.
   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      frame_open_in     = frame_open_ff;
      accepting_in      = accepting_ff;
      chunk_tag_in      = chunk_tag_ff;
      byte_count_in     = byte_count_ff;
      header_type_in    = header_type_ff;
      length_low_in     = length_low_ff;
      length_high_in    = length_high_ff;
      write_valid_in    = 1'b0;
      write_addr_in     = '0;
      write_data_in     = '0;
      frame_done_in     = 1'b0;
      frame_ok_in       = 1'b0;
      message_type_in   = '0;
      payload_length_in = '0;

      if (pop_item.chunk_start) begin
         chunk_tag_in = pop_item.chunk_byte;
         if (pop_item.first_tag) begin
            frame_open_in  = 1'b1;
            byte_count_in  = '0;
            header_type_in = '0;
            length_low_in  = '0;
            length_high_in = '0;
            accepting_in   = 1'b1;
         end else begin
            accepting_in = frame_open_ff;
         end
      end else if (accepting_ff && (byte_count_ff < CW'(BUFFER_BYTES))) begin
         write_valid_in = 1'b1;
         write_addr_in  = ADDR_W'(byte_count_ff);
         write_data_in  = pop_item.chunk_byte;
         if (byte_count_ff == CW'(HDR_TYPE_POS)) begin
            header_type_in = pop_item.chunk_byte;
         end else if (byte_count_ff == CW'(HDR_LEN_LO_POS)) begin
            length_low_in = pop_item.chunk_byte;
         end else if (byte_count_ff == CW'(HDR_LEN_HI_POS)) begin
            length_high_in = pop_item.chunk_byte;
         end
         byte_count_in = byte_count_ff + CW'(1);
      end

      // The close decision sees the state as updated by this byte.
      plen        = {length_high_in, length_low_in};
      have_header = byte_count_in >= CW'(HEADER_BYTES);
      fits        = have_header &&
                    ((CMP_W'(plen) + CMP_W'(HEADER_BYTES)) <= CMP_W'(byte_count_in));

      if (pop_item.chunk_end) begin
         if (accepting_in && ((chunk_tag_in == last_tag_code) ||
                              ((chunk_tag_in == first_tag_code) && fits))) begin
            frame_done_in = 1'b1;
            frame_ok_in   = fits;
            if (have_header) begin
               message_type_in   = header_type_in;
               payload_length_in = plen;
            end
            frame_open_in = 1'b0;
         end
         accepting_in = 1'b0;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         accepting_ff   <= 1'b0;
         chunk_tag_ff   <= '0;
         byte_count_ff  <= '0;
         header_type_ff <= '0;
         length_low_ff  <= '0;
         length_high_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            frame_open_ff  <= frame_open_in;
            accepting_ff   <= accepting_in;
            chunk_tag_ff   <= chunk_tag_in;
            byte_count_ff  <= byte_count_in;
            header_type_ff <= header_type_in;
            length_low_ff  <= length_low_in;
            length_high_ff <= length_high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         write_valid_ff    <= write_valid_in;
         write_addr_ff     <= write_addr_in;
         write_data_ff     <= write_data_in;
         frame_done_ff     <= frame_done_in;
         frame_ok_ff       <= frame_ok_in;
         message_type_ff   <= message_type_in;
         payload_length_ff <= payload_length_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_valid    = write_valid_ff;
   assign rsp_write_addr     = write_addr_ff;
   assign rsp_write_data     = write_data_ff;
   assign rsp_frame_done     = frame_done_ff;
   assign rsp_frame_ok       = frame_ok_ff;
   assign rsp_message_type   = message_type_ff;
   assign rsp_payload_length = payload_length_ff;

   `CHRSM_ASSERT_NOW(a_count_cap, 1'b1, byte_count_ff <= CW'(BUFFER_BYTES))
   `CHRSM_ASSERT_NOW(a_ok_needs_done, rsp_valid_ff && frame_ok_ff, frame_done_ff)

endmodule

@@ hdl/chunk_reassembler.sv @@
// Chunk reassembler top level: configuration registers, front, queue and back.
//
// Chunk bytes enter on the req_ channel, one byte per transfer, with
// req_chunk_start on the tag byte and req_chunk_end on the final byte of a
// chunk. Every input transfer yields exactly one result transfer on the rsp_
// channel: a buffer write (offset and data) for an accepted body byte, and
// frame_done with frame_ok, message_type and payload_length when a frame closes.
// The csr_ channel writes the FIRST and LAST tag codes; csr_ready is always high.
// A result goes from its input transfer through a queue slot into the back's
// result register, which presents it; one byte is taken per cycle when the
// receiver does not stall. The classified bytes pass through a four-entry
// queue; the back pops one per cycle into its result register while that
// register is free or being taken, so the sustained rate is set by that single state update stage.
// When rsp_stall is high the result holds, the queue fills and req_stall rises
// once it is full. Reset clears the frame state, empties the queue and loads
// the tag codes with their defaults (FIRST 1, LAST 3).
module chunk_reassembler #(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [chrsm_pkg::BYTE_W-1:0]        req_chunk_byte,
   input  logic                                req_chunk_start,
   input  logic                                req_chunk_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_write_valid,
   output logic [chrsm_pkg::ADDR_W-1:0]        rsp_write_addr,
   output logic [chrsm_pkg::BYTE_W-1:0]        rsp_write_data,
   output logic                                rsp_frame_done,
   output logic                                rsp_frame_ok,
   output logic [chrsm_pkg::BYTE_W-1:0]        rsp_message_type,
   output logic [chrsm_pkg::LEN_W-1:0]         rsp_payload_length,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [chrsm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [chrsm_pkg::BYTE_W-1:0]        csr_data
);
   import chrsm_pkg::*;

   logic [BYTE_W-1:0] first_tag_ff;
   logic [BYTE_W-1:0] last_tag_ff;
   queue_status_type  q_status;
   logic              push;
   logic              pop;
   item_type          push_item;
   item_type          pop_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_tag_ff <= FIRST_TAG_RESET;
         last_tag_ff  <= LAST_TAG_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FIRST_TAG) begin
            first_tag_ff <= csr_data;
         end else if (csr_index == CSR_LAST_TAG) begin
            last_tag_ff <= csr_data;
         end
      end
   end

   chrsm_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_chunk_byte  (req_chunk_byte),
      .req_chunk_start (req_chunk_start),
      .req_chunk_end   (req_chunk_end),
      .first_tag_code  (first_tag_ff),
      .q_status        (q_status),
      .push            (push),
      .push_item       (push_item)
   );

   chrsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   chrsm_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .first_tag_code     (first_tag_ff),
      .last_tag_code      (last_tag_ff),
      .q_status           (q_status),
      .pop_item           (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_addr     (rsp_write_addr),
      .rsp_write_data     (rsp_write_data),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_message_type   (rsp_message_type),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

@@ verif/chunk_reassembler_checker.sv @@
// Checker for the chunk reassembler: predicts every result transfer and compares it.
module chunk_reassembler_checker #(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [chrsm_pkg::BYTE_W-1:0]      req_chunk_byte,
   input  logic                              req_chunk_start,
   input  logic                              req_chunk_end,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_write_valid,
   input  logic [chrsm_pkg::ADDR_W-1:0]      rsp_write_addr,
   input  logic [chrsm_pkg::BYTE_W-1:0]      rsp_write_data,
   input  logic                              rsp_frame_done,
   input  logic                              rsp_frame_ok,
   input  logic [chrsm_pkg::BYTE_W-1:0]      rsp_message_type,
   input  logic [chrsm_pkg::LEN_W-1:0]       rsp_payload_length,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [chrsm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [chrsm_pkg::BYTE_W-1:0]      csr_data,
   output int                                fail_count,
   output int                                pending
);
   import chrsm_pkg::*;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_addr;
      logic [BYTE_W-1:0] write_data;
      logic              frame_done;
      logic              frame_ok;
      logic [BYTE_W-1:0] message_type;
      logic [LEN_W-1:0]  payload_length;
   } frame_event_type;

   frame_event_type frame_events[$];

   logic [BYTE_W-1:0] first_code;
   logic [BYTE_W-1:0] last_code;
   logic [BYTE_W-1:0] cur_tag;
   logic [BYTE_W-1:0] hdr_type;
   logic [BYTE_W-1:0] len_lo;
   logic [BYTE_W-1:0] len_hi;
   logic              in_frame;
   logic              taking_body;
   int                stored;

   // Advances the frame state by one byte and returns the result it causes.
   function automatic frame_event_type absorb_byte(input logic [BYTE_W-1:0] b,
                                                   input logic s, input logic e);
      frame_event_type  ev;
      logic             have;
      logic             fits;
      logic [LEN_W-1:0] plen;
      ev = '0;
      if (s) begin
         cur_tag = b;
         if (b == first_code) begin
            in_frame    = 1'b1;
            stored      = 0;
            hdr_type    = '0;
            len_lo      = '0;
            len_hi      = '0;
            taking_body = 1'b1;
         end else begin
            taking_body = in_frame;
         end
      end else if (taking_body && stored < BUFFER_BYTES) begin
         ev.write_valid = 1'b1;
         ev.write_addr  = stored[ADDR_W-1:0];
         ev.write_data  = b;
         if (stored == HDR_TYPE_POS) hdr_type = b;
         else if (stored == HDR_LEN_LO_POS) len_lo = b;
         else if (stored == HDR_LEN_HI_POS) len_hi = b;
         stored++;
      end
      if (e) begin
         if (taking_body) begin
            have = stored >= HEADER_BYTES;
            plen = {len_hi, len_lo};
            fits = have && (int'(plen) + HEADER_BYTES <= stored);
            if (cur_tag == last_code || (cur_tag == first_code && fits)) begin
               ev.frame_done = 1'b1;
               ev.frame_ok   = fits;
               if (have) begin
                  ev.message_type   = hdr_type;
                  ev.payload_length = plen;
               end
               in_frame = 1'b0;
            end
         end
         taking_body = 1'b0;
      end
      return ev;
   endfunction

   function automatic string show(input frame_event_type ev);
      return $sformatf("wv=%0b addr=%0d data=%02h done=%0b ok=%0b type=%02h len=%04h",
                       ev.write_valid, ev.write_addr, ev.write_data, ev.frame_done,
                       ev.frame_ok, ev.message_type, ev.payload_length);
   endfunction

   always @(posedge clock) begin
      frame_event_type got;
      frame_event_type want;
      if (reset) begin
         first_code  = FIRST_TAG_RESET;
         last_code   = LAST_TAG_RESET;
         cur_tag     = '0;
         hdr_type    = '0;
         len_lo      = '0;
         len_hi      = '0;
         in_frame    = 1'b0;
         taking_body = 1'b0;
         stored      = 0;
         frame_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIRST_TAG) first_code = csr_data;
            else if (csr_index == CSR_LAST_TAG) last_code = csr_data;
         end
         if (req_valid && !req_stall)
            frame_events.push_back(absorb_byte(req_chunk_byte, req_chunk_start,
                                               req_chunk_end));
         if (rsp_valid && !rsp_stall) begin
            got.write_valid    = rsp_write_valid;
            got.write_addr     = rsp_write_addr;
            got.write_data     = rsp_write_data;
            got.frame_done     = rsp_frame_done;
            got.frame_ok       = rsp_frame_ok;
            got.message_type   = rsp_message_type;
            got.payload_length = rsp_payload_length;
            if (frame_events.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result transfer, got %s", $time, show(got));
            end else begin
               want = frame_events.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result mismatch, expected %s, got %s",
                              $time, show(want), show(got));
               end
            end
         end
      end
      pending = frame_events.size();
   end

endmodule

@@ verif/tb_chunk_reassembler.sv @@
// Testbench top for the chunk reassembler: clock, reset, stimulus and verdict.
module tb_chunk_reassembler;
   import chrsm_pkg::*;

   localparam int BUFFER_BYTES = 1024;
   localparam int HOLD_CYCLES  = 120;
   localparam int TAIL_CYCLES  = 8;
   localparam int IDLE_LIMIT   = 2000;

   typedef logic [BYTE_W-1:0] octet_q_type[$];

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_chunk_byte;
   logic                   req_chunk_start;
   logic                   req_chunk_end;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_write_valid;
   logic [ADDR_W-1:0]      rsp_write_addr;
   logic [BYTE_W-1:0]      rsp_write_data;
   logic                   rsp_frame_done;
   logic                   rsp_frame_ok;
   logic [BYTE_W-1:0]      rsp_message_type;
   logic [LEN_W-1:0]       rsp_payload_length;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_data;

   int fail_count;
   int pending;

   logic              req_taken = 1'b0;
   logic              csr_taken = 1'b0;
   logic              hold_pending = 1'b0;
   logic              calm_tx = 1'b0;
   logic              calm_rx = 1'b0;
   logic [BYTE_W-1:0] cur_first = FIRST_TAG_RESET;
   logic [BYTE_W-1:0] cur_last = LAST_TAG_RESET;
   int                items_sent = 0;
   int                idle_cycles = 0;

   chunk_reassembler #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_chunk_byte    (req_chunk_byte),
      .req_chunk_start   (req_chunk_start),
      .req_chunk_end     (req_chunk_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_addr    (rsp_write_addr),
      .rsp_write_data    (rsp_write_data),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_message_type  (rsp_message_type),
      .rsp_payload_length(rsp_payload_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   chunk_reassembler_checker #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_chunk_byte    (req_chunk_byte),
      .req_chunk_start   (req_chunk_start),
      .req_chunk_end     (req_chunk_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_addr    (rsp_write_addr),
      .rsp_write_data    (rsp_write_data),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_message_type  (rsp_message_type),
      .rsp_payload_length(rsp_payload_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The drivers look at these flags at the falling edge to learn whether the
   // transfer they offered went through at the rising edge before it.
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      csr_taken <= csr_valid && csr_ready;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // Receiver: random stalls, and one long hold-off when the stimulus asks for it.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            n = HOLD_CYCLES;
         end else begin
            n = calm_rx ? 0 : pick_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic s, input logic e);
      int gap;
      gap = calm_tx ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_chunk_byte  <= b;
      req_chunk_start <= s;
      req_chunk_end   <= e;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      while (!csr_taken) @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stops offering bytes until every predicted result has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] other_tag();
      logic [BYTE_W-1:0] t;
      do t = BYTE_W'($urandom_range(0, 255)); while (t == cur_first || t == cur_last);
      return t;
   endfunction

   function automatic octet_q_type slice(input octet_q_type q, input int from, input int n);
      octet_q_type r;
      r = {};
      for (int i = from; i < from + n; i++) r.push_back(q[i]);
      return r;
   endfunction

   task automatic send_chunk(input logic [BYTE_W-1:0] tag, input octet_q_type body,
                             input logic with_end);
      if (body.size() == 0) begin
         push_byte(tag, 1'b1, with_end);
      end else begin
         push_byte(tag, 1'b1, 1'b0);
         foreach (body[i]) push_byte(body[i], 1'b0, with_end && i == body.size() - 1);
      end
   endtask

   task automatic send_noise();
      int               n;
      int               r;
      logic [BYTE_W-1:0] b;
      n = $urandom_range(1, 4);
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r < 2) b = cur_first;
         else if (r < 3) b = cur_last;
         else b = BYTE_W'($urandom_range(0, 255));
         push_byte(b, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
      end
   endtask

   // Sends one frame split at random into a FIRST chunk, continuation chunks
   // and a LAST chunk, which may be left out if the FIRST chunk holds it all;
   // a broken frame loses chunk ends, gets noise between chunks or ends early.
   task automatic send_frame(input int plen_field, input int total, input logic broken);
      octet_q_type data;
      int          pos;
      int          n;
      data = {};
      data.push_back(BYTE_W'($urandom_range(0, 255)));
      data.push_back(plen_field[7:0]);
      data.push_back(plen_field[15:8]);
      while (data.size() < total) data.push_back(BYTE_W'($urandom_range(0, 255)));
      while (data.size() > total) void'(data.pop_back());
      n = $urandom_range(0, total);
      send_chunk(cur_first, slice(data, 0, n), !(broken && $urandom_range(0, 2) == 0));
      pos = n;
      if (pos == total && $urandom_range(0, 1)) return;
      while (pos < total && $urandom_range(0, 2) != 0) begin
         n = $urandom_range(1, total - pos);
         if (broken && $urandom_range(0, 3) == 0) send_noise();
         send_chunk(other_tag(), slice(data, pos, n), !(broken && $urandom_range(0, 3) == 0));
         pos += n;
      end
      if (broken && $urandom_range(0, 1)) return;
      send_chunk(cur_last, slice(data, pos, total - pos), 1'b1);
   endtask

   task automatic run_random(input int target);
      int r;
      int plen_field;
      int total;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            calm_tx = $urandom_range(0, 2) == 0;
            calm_rx = $urandom_range(0, 2) == 0;
         end
         if (r < 88) begin
            plen_field = $urandom_range(0, 8);
            total      = HEADER_BYTES + plen_field;
            // Now and then the length field is nonsense or the body too short or long.
            if ($urandom_range(0, 9) == 0) plen_field = $urandom_range(0, 65535);
            if ($urandom_range(0, 4) == 0) total = $urandom_range(0, total + 3);
            send_frame(plen_field, total, r >= 72);
         end else begin
            send_noise();
         end
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] f;
      logic [BYTE_W-1:0] l;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_chunk_byte  = '0;
      req_chunk_start = 1'b0;
      req_chunk_end   = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_FIRST_TAG;
      csr_data        = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A whole frame held in its FIRST chunk, so it closes on that chunk.
      push_byte(cur_first, 1'b1, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h02, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hAA, 1'b0, 1'b1);
      // A stray chunk with no frame open, then a byte outside any chunk.
      push_byte(cur_last, 1'b1, 1'b0);
      push_byte(8'h55, 1'b0, 1'b1);
      push_byte(8'h80, 1'b0, 1'b0);
      // A short FIRST chunk with an all-ones length, continued and then closed
      // by a LAST chunk that is nothing but its tag.
      push_byte(cur_first, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(other_tag(), 1'b1, 1'b0);
      push_byte(8'h11, 1'b0, 1'b1);
      push_byte(cur_last, 1'b1, 1'b1);
      // A LAST chunk that closes a frame without a full header.
      push_byte(cur_first, 1'b1, 1'b0);
      push_byte(8'h01, 1'b0, 1'b1);
      push_byte(cur_last, 1'b1, 1'b1);
      // A chunk that never ends, overtaken by a new FIRST tag.
      push_byte(cur_first, 1'b1, 1'b0);
      push_byte(8'h22, 1'b0, 1'b0);
      push_byte(cur_first, 1'b1, 1'b0);
      push_byte(8'h05, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);

      run_random(items_sent + 60);

      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: begin
               f = 8'h00;
               l = 8'hFF;
            end
            1: begin
               f = 8'hFF;
               l = 8'h00;
            end
            2: begin
               f = 8'h07;
               l = 8'h07;
            end
            3: begin
               f = 8'hC8;
               l = 8'hC9;
            end
            default: begin
               f = BYTE_W'($urandom_range(0, 255));
               l = BYTE_W'($urandom_range(0, 255));
            end
         endcase
         write_csr(CSR_FIRST_TAG, f);
         write_csr(CSR_LAST_TAG, l);
         cur_first = f;
         cur_last  = l;
         if (p == 2) hold_pending = 1'b1;
         // One frame long enough to fill the buffer and at times run past its end.
         if (p == 3) send_frame($urandom_range(1016, 1023), 1024 + $urandom_range(0, 6), 1'b0);
         run_random(items_sent + 45);
         if (p == 1) drain();
         run_random(items_sent + 45);
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ chunk_reassembler.f @@
+incdir+hdl
hdl/chrsm_pkg.sv
hdl/chrsm_front.sv
hdl/chrsm_queue.sv
hdl/chrsm_back.sv
hdl/chunk_reassembler.sv
verif/chunk_reassembler_checker.sv
verif/tb_chunk_reassembler.sv
